>>> design/bmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmi_pkg: shared definitions for the binary modular inverse block
// Holds default sizes, reset values, the controller state type and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package bmi_pkg;

  // Default operand width used inside the datapath
  localparam int DEF_WIDTH = 32;

  // Fixed widths of the external fields
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // Modulus register after reset
  localparam logic [VALUE_W-1:0] MODULUS_RESET = VALUE_W'(3);

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bmi_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture a new value and initialize the pairs
    logic step;  // perform one iteration
  } bmi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic loop_done;  // range error, v reached zero, or iteration limit
  } bmi_status_t;

endpackage

>>> design/binary_modular_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_modular_inverse: modular inverse by binary extended Euclid
// Computes the inverse of value modulo the programmed odd modulus and the
// number of halving steps taken, flagging values outside 1 to modulus.
// ----------------------------------------------------------------------------
// A transaction is accepted on a clock edge with start high and busy low.
// The datapath performs one halving or subtract step per cycle; the
// number of steps n is data dependent and capped at 4*WIDTH+8, and an
// out-of-range value finishes with n = 0. The result is shown for
// exactly one cycle with done high and must be taken then, since the
// receiver cannot stall the block. The user must write the modulus with
// modulus_we and modulus_data only while the block is idle; the block
// itself does not enforce this.
module binary_modular_inverse #(
  parameter int WIDTH = bmi_pkg::DEF_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        modulus_we,
  input  logic [bmi_pkg::VALUE_W-1:0] modulus_data,
  input  logic                        start,
  input  logic [bmi_pkg::VALUE_W-1:0] value,
  output logic                        busy,
  output logic                        done,
  output logic [bmi_pkg::VALUE_W-1:0] inverse,
  output logic [bmi_pkg::COUNT_W-1:0] halving_count,
  output logic                        range_error
);
  import bmi_pkg::*;

  bmi_cmd_t    cmd;
  bmi_status_t status;

  // Sequence the transaction
  bmi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Compute the inverse
  bmi_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .modulus_we    (modulus_we),
    .modulus_data  (modulus_data),
    .value         (value),
    .cmd           (cmd),
    .status        (status),
    .inverse       (inverse),
    .halving_count (halving_count),
    .range_error   (range_error)
  );

  // Result strobes only while a transaction is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  // Range error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (inverse == '0 && halving_count == '0))
    else $error("range error with nonzero result");

  // Accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");

  // Block frees up after the result
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("still busy after result");

endmodule

>>> design/bmi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmi_ctrl: sequencer for the binary modular inverse
// Accepts a transaction when idle, steps the datapath until it reports the
// loop finished, then strobes the result for one cycle.
// ----------------------------------------------------------------------------
module bmi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  bmi_pkg::bmi_status_t status,
  output bmi_pkg::bmi_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import bmi_pkg::*;

  bmi_state_t state;
  bmi_state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.loop_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive commands and strobes
  always_comb begin
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    busy     = 1'b0;
    done     = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_RUN: begin
        busy     = 1'b1;
        cmd.step = !status.loop_done;
        done     = status.loop_done;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

>>> design/bmi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmi_datapath: registers and arithmetic of the binary inversion
// Holds the modulus register and the pairs (u,r) and (v,s); one halving
// or subtract-and-reduce step is done per step command.
// ----------------------------------------------------------------------------
module bmi_datapath #(
  parameter int WIDTH = bmi_pkg::DEF_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          modulus_we,
  input  logic [bmi_pkg::VALUE_W-1:0]   modulus_data,
  input  logic [bmi_pkg::VALUE_W-1:0]   value,
  input  bmi_pkg::bmi_cmd_t             cmd,
  output bmi_pkg::bmi_status_t          status,
  output logic [bmi_pkg::VALUE_W-1:0]   inverse,
  output logic [bmi_pkg::COUNT_W-1:0]   halving_count,
  output logic                          range_error
);
  import bmi_pkg::*;

  localparam int LIMIT  = 4 * WIDTH + 8;
  localparam int ITER_W = $clog2(LIMIT + 1);

  logic [VALUE_W-1:0] modulus;
  logic [WIDTH-1:0]   m;
  logic [WIDTH-1:0]   a;
  logic [63:0]        modulus_ext;
  logic [63:0]        value_ext;
  logic [63:0]        r_ext;

  logic [WIDTH-1:0]   u;
  logic [WIDTH-1:0]   v;
  logic [WIDTH-1:0]   r;
  logic [WIDTH-1:0]   s;
  logic [COUNT_W-1:0] k;
  logic [ITER_W-1:0]  iter;
  logic               err;

  logic [WIDTH:0]     r_half_sum;
  logic [WIDTH:0]     s_half_sum;
  logic [WIDTH-1:0]   r_sub;
  logic [WIDTH-1:0]   s_sub;
  logic               a_bad;

  // Hold the modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (modulus_we) begin
      modulus <= modulus_data;
    end
  end

  // Trim or extend the fields to the operand width
  assign modulus_ext = 64'(modulus);
  assign value_ext   = 64'(value);
  assign m           = modulus_ext[WIDTH-1:0];
  assign a           = value_ext[WIDTH-1:0];
  assign a_bad       = (a == '0) || (a > m);

  // Halve modulo m: add m first when odd
  assign r_half_sum = {1'b0, r} + (r[0] ? {1'b0, m} : '0);
  assign s_half_sum = {1'b0, s} + (s[0] ? {1'b0, m} : '0);

  // Subtract modulo m: add m back on borrow
  assign r_sub = r - s + ((r < s) ? m : '0);
  assign s_sub = s - r + ((s < r) ? m : '0);

  // Load and iterate
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u    <= m;
      v    <= a;
      r    <= '0;
      s    <= WIDTH'(1);
      k    <= '0;
      iter <= '0;
      err  <= a_bad;
    end else if (cmd.step) begin
      iter <= iter + ITER_W'(1);
      if (!u[0]) begin
        u <= u >> 1;
        r <= r_half_sum[WIDTH:1];
        k <= k + COUNT_W'(1);
      end else if (!v[0]) begin
        v <= v >> 1;
        s <= s_half_sum[WIDTH:1];
        k <= k + COUNT_W'(1);
      end else if (u > v) begin
        u <= u - v;
        r <= r_sub;
      end else begin
        v <= v - u;
        s <= s_sub;
      end
    end
  end

  // Report loop end
  assign status.loop_done = err || (v == '0) || (iter == ITER_W'(LIMIT));

  // Drive result fields
  assign r_ext         = 64'(r);
  assign inverse       = r_ext[VALUE_W-1:0];
  assign halving_count = k;
  assign range_error   = err;

endmodule

>>> dv/binary_modular_inverse_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_modular_inverse_test: self-checking bench for the modular inverse
// Feeds values through a command-style driver, predicts each inverse and
// halving count with a local binary Euclid model, and checks every result
// strobe against the oldest prediction. The modulus is reprogrammed between
// phases while the block is idle, covering extreme, small and even moduli.
// ----------------------------------------------------------------------------
module binary_modular_inverse_test;
  import bmi_pkg::*;

  localparam int WIDTH        = 32;
  localparam int LOOP_LIMIT   = 4 * WIDTH + 8;
  localparam int RANDOM_ITEMS = 1050;
  localparam int QUIET_TAIL   = 100;
  localparam int DRAIN_CYCLES = LOOP_LIMIT + 16;
  localparam int SETTLE_IDLE  = 2;

  typedef enum logic {
    OP_VALUE,
    OP_MODULUS
  } op_kind_t;

  typedef struct {
    op_kind_t           kind;
    logic [VALUE_W-1:0] data;
    logic               no_idle;
  } pending_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] inverse;
    logic [COUNT_W-1:0] halving_count;
    logic               range_error;
  } inv_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               modulus_we = 1'b0;
  logic [VALUE_W-1:0] modulus_data = '0;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               done;
  logic [VALUE_W-1:0] inverse;
  logic [COUNT_W-1:0] halving_count;
  logic               range_error;

  pending_op_t        pending_q[$];
  inv_result_t        expected_q[$];
  logic [VALUE_W-1:0] cur_modulus = MODULUS_RESET;
  logic               cur_no_idle = 1'b0;
  int                 gap_cnt = 0;
  int                 idle_run = 0;
  int                 error_cnt = 0;
  int                 results_checked = 0;
  int                 range_errors_seen = 0;
  int                 modulus_writes = 0;

  binary_modular_inverse #(.WIDTH(WIDTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .modulus_we   (modulus_we),
    .modulus_data (modulus_data),
    .start        (start),
    .value        (value),
    .busy         (busy),
    .done         (done),
    .inverse      (inverse),
    .halving_count(halving_count),
    .range_error  (range_error)
  );

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hold reset at the start of the run, once
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Binary extended Euclid: inverse of val modulo mod, plus halving count
  function automatic inv_result_t predict_inverse(logic [VALUE_W-1:0] mod_reg,
                                                  logic [VALUE_W-1:0] val);
    logic [63:0] m, u, v, r, s;
    int unsigned halvings;
    int unsigned iter;
    inv_result_t res;
    m = 64'(mod_reg);
    u = m;
    v = 64'(val);
    r = 64'd0;
    s = 64'd1;
    halvings = 0;
    iter = 0;
    res = '0;
    if (v < 64'd1 || v > m) begin
      res.range_error = 1'b1;
      return res;
    end
    while (v != 64'd0 && iter < LOOP_LIMIT) begin
      iter++;
      if (!u[0]) begin
        u = u >> 1;
        r = r[0] ? (r + m) >> 1 : r >> 1;
        halvings++;
      end else if (!v[0]) begin
        v = v >> 1;
        s = s[0] ? (s + m) >> 1 : s >> 1;
        halvings++;
      end else if (u > v) begin
        u = u - v;
        r = (r >= s) ? r - s : r + m - s;
      end else begin
        v = v - u;
        s = (s >= r) ? s - r : s + m - r;
      end
    end
    res.inverse       = r[VALUE_W-1:0];
    res.halving_count = halvings[COUNT_W-1:0];
    return res;
  endfunction

  // Driver: present queued values, reprogram the modulus only when idle
  always @(posedge clk) begin : driver
    logic               accepted;
    logic               nxt_start;
    logic               nxt_we;
    logic [VALUE_W-1:0] nxt_value;
    logic [VALUE_W-1:0] nxt_mod;
    pending_op_t        op;
    if (rst) begin
      start        <= 1'b0;
      value        <= '0;
      modulus_we   <= 1'b0;
      modulus_data <= '0;
      gap_cnt      = 0;
      idle_run     = 0;
    end else begin
      accepted  = start && !busy;
      nxt_start = start && !accepted;
      nxt_value = value;
      nxt_we    = 1'b0;
      nxt_mod   = modulus_data;

      // record the prediction for each accepted transaction
      if (accepted) begin
        expected_q.push_back(predict_inverse(cur_modulus, value));
        if (cur_no_idle || $urandom_range(1, 0) == 0) gap_cnt = 0;
        else gap_cnt = $urandom_range(4, 1);
      end else if (gap_cnt > 0 && !busy) begin
        gap_cnt--;
      end

      // count quiet cycles before a modulus write
      if (!start && !busy && expected_q.size() == 0) idle_run++;
      else idle_run = 0;

      // issue the next pending operation
      if (!nxt_start && gap_cnt == 0 && pending_q.size() != 0) begin
        op = pending_q[0];
        if (op.kind == OP_VALUE) begin
          void'(pending_q.pop_front());
          nxt_start   = 1'b1;
          nxt_value   = op.data;
          cur_no_idle = op.no_idle;
        end else if (!busy && expected_q.size() == 0 && idle_run >= SETTLE_IDLE) begin
          void'(pending_q.pop_front());
          nxt_we      = 1'b1;
          nxt_mod     = op.data;
          cur_modulus = op.data;
          modulus_writes++;
          idle_run    = 0;
        end
      end

      start        <= nxt_start;
      value        <= nxt_value;
      modulus_we   <= nxt_we;
      modulus_data <= nxt_mod;
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin : monitor
    inv_result_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: inverse=%0h halving_count=%0d range_error=%0b",
               inverse, halving_count, range_error);
        error_cnt++;
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (want.range_error) range_errors_seen++;
        if (inverse !== want.inverse) begin
          $error("inverse: expected %0h, actual %0h", want.inverse, inverse);
          error_cnt++;
        end
        if (halving_count !== want.halving_count) begin
          $error("halving_count: expected %0d, actual %0d",
                 want.halving_count, halving_count);
          error_cnt++;
        end
        if (range_error !== want.range_error) begin
          $error("range_error: expected %0b, actual %0b",
                 want.range_error, range_error);
          error_cnt++;
        end
      end
    end
  end

  task automatic queue_value(logic [VALUE_W-1:0] data, logic no_idle);
    pending_op_t op;
    op.kind    = OP_VALUE;
    op.data    = data;
    op.no_idle = no_idle;
    pending_q.push_back(op);
  endtask

  task automatic queue_modulus(logic [VALUE_W-1:0] data);
    pending_op_t op;
    op.kind    = OP_MODULUS;
    op.data    = data;
    op.no_idle = 1'b0;
    pending_q.push_back(op);
  endtask

  function automatic logic [VALUE_W-1:0] pick_modulus();
    logic [VALUE_W-1:0] m;
    case ($urandom_range(4, 0))
      0: m = VALUE_W'($urandom_range(255, 3)) | 1;
      1: m = VALUE_W'($urandom) | 1;
      2: m = 32'hFFFF_FFFF - VALUE_W'($urandom_range(64, 0) * 2);
      3: m = (VALUE_W'($urandom) >> $urandom_range(28, 0)) | 1;
      default: m = VALUE_W'($urandom) & ~VALUE_W'(1);
    endcase
    if (m < 3) m = 3;
    return m;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(logic [VALUE_W-1:0] m);
    case ($urandom_range(19, 0))
      0: return '0;
      1: return m;
      2: return (m == 32'hFFFF_FFFF) ? VALUE_W'($urandom) : m + 1;
      3: return VALUE_W'($urandom);
      default: return VALUE_W'($urandom_range(m, 1));
    endcase
  endfunction

  // Stimulus: directed corners, then random phases of modulus and values
  initial begin : stimulus
    logic [VALUE_W-1:0] m;
    int phase_len;
    int issued;

    // reset modulus of 3: zero, in range, equal, above, all ones
    queue_value(32'd0, 1'b0);
    queue_value(32'd1, 1'b0);
    queue_value(32'd2, 1'b0);
    queue_value(32'd3, 1'b0);
    queue_value(32'd4, 1'b0);
    queue_value(32'hFFFF_FFFF, 1'b0);

    // largest modulus: not coprime to 3, top bit, equal value
    queue_modulus(32'hFFFF_FFFF);
    queue_value(32'd1, 1'b0);
    queue_value(32'd3, 1'b0);
    queue_value(32'h8000_0000, 1'b0);
    queue_value(32'hFFFF_FFFE, 1'b0);
    queue_value(32'hFFFF_FFFF, 1'b0);
    queue_value(32'd0, 1'b0);

    // largest 32-bit prime
    queue_modulus(32'd4294967291);
    queue_value(32'd1, 1'b0);
    queue_value(32'd2, 1'b0);
    queue_value(32'd4294967290, 1'b0);
    queue_value(32'd4294967291, 1'b0);
    queue_value(32'hFFFF_FFFF, 1'b0);

    // even moduli, where the inverse is still checked against the model
    queue_modulus(32'd10);
    queue_value(32'd3, 1'b0);
    queue_value(32'd4, 1'b0);
    queue_value(32'd11, 1'b0);
    queue_modulus(32'hFFFF_FFFE);
    queue_value(32'h5555_5555, 1'b0);
    queue_value(32'hAAAA_AAAA, 1'b0);

    // random phases, no idle gaps between values in the tail
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      m = pick_modulus();
      queue_modulus(m);
      phase_len = $urandom_range(120, 40);
      for (int i = 0; i < phase_len && issued < RANDOM_ITEMS; i++) begin
        queue_value(pick_value(m), issued >= RANDOM_ITEMS - QUIET_TAIL);
        issued++;
      end
    end

    // drain: all issued, all results seen, then let the block settle
    @(posedge clk);
    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d results checked across %0d modulus writes, %0d range errors",
             results_checked, modulus_writes, range_errors_seen);
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout well beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
design/bmi_pkg.sv
design/bmi_ctrl.sv
design/bmi_datapath.sv
design/binary_modular_inverse.sv
dv/binary_modular_inverse_test.sv
